// ----- sv/tsc_pkg.sv -----
package tsc_pkg;

    localparam int StatusW = 3;
    localparam int TempW   = 26;
    localparam int RawW    = 16;

    localparam logic [StatusW-1:0] ST_SUCCESS  = 3'd0;
    localparam logic [StatusW-1:0] ST_BUS      = 3'd1;
    localparam logic [StatusW-1:0] ST_SILENCE  = 3'd2;
    localparam logic [StatusW-1:0] ST_CHECKSUM = 3'd3;
    localparam logic [StatusW-1:0] ST_RESETVAL = 3'd4;

    // Front to back: final status is decided up front, back only scales.
    typedef struct packed {
        logic [StatusW-1:0]     status;
        logic signed [RawW-1:0] raw;
    } t_cmd;

    typedef struct packed {
        logic [StatusW-1:0]      status;
        logic signed [TempW-1:0] temp_e4;
    } t_result;

endpackage

// ----- sv/temp_sensor_scratchpad_check.sv -----
// Channel   Direction  Handshake           Payload
// input     in         push / full         i_data_byte[7:0], i_no_presence
// result    out        empty / pop         o_status[2:0], o_temperature_e4[25:0] signed
//
// One byte per cycle while full is low. A frame-ending or bus-error byte reaches
// the result queue through the command queue, then the scale register.
// Synchronous active-low reset empties both queues and restarts the frame.
// full follows the command queue; a stalled result side backs up through
// the scale register into it, byte intake continues until it fills.
module temp_sensor_scratchpad_check #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_no_presence,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic signed [25:0] o_temperature_e4
);

    logic              accept;
    logic              cmd_push, cmd_pop, cmd_empty;
    tsc_pkg::t_cmd     cmd_wr, cmd_rd;
    logic              res_push, res_full;
    tsc_pkg::t_result  res_wr, res_rd;

    assign accept = push && !full;

    tsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_no_presence (i_no_presence),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_wr)
    );

    tsc_fifo #(
        .WIDTH ($bits(tsc_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (cmd_push),
        .i_wdata (cmd_wr),
        .o_full  (full),
        .i_rd_en (cmd_pop),
        .o_rdata (cmd_rd),
        .o_empty (cmd_empty)
    );

    tsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_rd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res_wr),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    tsc_fifo #(
        .WIDTH ($bits(tsc_pkg::t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (res_push),
        .i_wdata (res_wr),
        .o_full  (res_full),
        .i_rd_en (pop),
        .o_rdata (res_rd),
        .o_empty (empty)
    );

    assign o_status         = res_rd.status;
    assign o_temperature_e4 = res_rd.temp_e4;

endmodule

// ----- sv/tsc_fifo.sv -----
// Small register queue; DEPTH must be at least 2.
module tsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             wr, rd;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr      = i_wr_en && !o_full;
    assign rd      = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/tsc_front.sv -----
// Byte intake: CRC, all-ones flag, raw temperature capture, frame classification.
module tsc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_no_presence,
    output logic            o_cmd_push,
    output tsc_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] LastIdx = 4'd8;
    localparam logic [7:0] CrcPoly = 8'h8C;
    // raw * 625 == 850000 exactly when raw == 1360
    localparam logic signed [tsc_pkg::RawW-1:0] ResetRaw = 16'sd1360;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[0];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CrcPoly;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

    logic [3:0] r_byte_index, n_byte_index;
    logic [7:0] r_crc, n_crc;
    logic       r_all_ones, n_all_ones;
    logic [7:0] r_raw_lo, n_raw_lo;
    logic [7:0] r_raw_hi, n_raw_hi;
    logic signed [tsc_pkg::RawW-1:0] raw;

    assign raw = {r_raw_hi, r_raw_lo};

    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_all_ones   = r_all_ones;
        n_raw_lo     = r_raw_lo;
        n_raw_hi     = r_raw_hi;
        o_cmd_push   = 1'b0;
        o_cmd.status = tsc_pkg::ST_BUS;
        o_cmd.raw    = raw;
        if (i_accept) begin
            if (i_no_presence || r_byte_index >= LastIdx) begin
                o_cmd_push   = 1'b1;
                n_byte_index = '0;
                n_crc        = '0;
                n_all_ones   = 1'b1;
                n_raw_lo     = '0;
                n_raw_hi     = '0;
                if (i_no_presence) begin
                    o_cmd.status = tsc_pkg::ST_BUS;
                end else if (r_all_ones) begin
                    o_cmd.status = tsc_pkg::ST_SILENCE;
                end else if (r_crc != i_data_byte) begin
                    o_cmd.status = tsc_pkg::ST_CHECKSUM;
                end else if (raw == ResetRaw) begin
                    o_cmd.status = tsc_pkg::ST_RESETVAL;
                end else begin
                    o_cmd.status = tsc_pkg::ST_SUCCESS;
                end
            end else begin
                n_byte_index = r_byte_index + 1'b1;
                n_crc        = crc8_update(r_crc, i_data_byte);
                if (i_data_byte != 8'hFF) begin
                    n_all_ones = 1'b0;
                end
                if (r_byte_index == 4'd0) begin
                    n_raw_lo = i_data_byte;
                end else if (r_byte_index == 4'd1) begin
                    n_raw_hi = i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= '0;
            r_all_ones   <= 1'b1;
            r_raw_lo     <= '0;
            r_raw_hi     <= '0;
        end else begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_all_ones   <= n_all_ones;
            r_raw_lo     <= n_raw_lo;
            r_raw_hi     <= n_raw_hi;
        end
    end

endmodule

// ----- sv/tsc_back.sv -----
// Scaling stage: takes a command, multiplies raw by 625 (temperature zero on error statuses), holds the result
// until the result queue has room.
module tsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsc_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output tsc_pkg::t_result  o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    localparam logic signed [tsc_pkg::TempW-1:0] Scale = 26'sd625;

    logic              r_valid;
    tsc_pkg::t_result  r_res, n_res;
    logic              advance;
    logic signed [tsc_pkg::TempW-1:0] raw_ext;

    assign advance    = !r_valid || !i_res_full;
    assign o_cmd_pop  = advance && !i_cmd_empty;
    assign o_res_push = r_valid && !i_res_full;
    assign o_res      = r_res;
    assign raw_ext    = tsc_pkg::TempW'(i_cmd.raw);

    always_comb begin
        n_res.status = i_cmd.status;
        if (i_cmd.status == tsc_pkg::ST_SUCCESS || i_cmd.status == tsc_pkg::ST_RESETVAL) begin
            n_res.temp_e4 = raw_ext * Scale;
        end else begin
            n_res.temp_e4 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= !i_cmd_empty;
        end
    end

endmodule

// ----- tb/temp_sensor_scratchpad_check_monitor.sv -----
`timescale 1ns / 1ps

module temp_sensor_scratchpad_check_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_no_presence,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [2:0]         i_status,
    input  logic signed [25:0] i_temperature_e4,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    localparam logic [3:0] LastByte    = 4'd8;
    localparam logic [7:0] CrcPoly     = 8'h8C;
    localparam int         ScaleE4     = 625;
    localparam int         ResetTempE4 = 850000;

    // frame state mirrored from the scratchpad decoder
    logic [3:0] byte_idx     = '0;
    logic [7:0] crc_acc      = '0;
    logic       all_ff       = 1'b1;
    logic [7:0] temp_lo      = '0;
    logic [7:0] temp_hi      = '0;

    tsc_pkg::t_result pending_results[$];
    int               fail_count   = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = pending_results.size();

    // reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CrcPoly;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

    function automatic tsc_pkg::t_result decode_frame(logic [7:0] check_byte);
        tsc_pkg::t_result   r;
        logic signed [15:0] raw;
        int                 scaled;
        r.status  = tsc_pkg::ST_SUCCESS;
        r.temp_e4 = '0;
        if (all_ff) begin
            r.status = tsc_pkg::ST_SILENCE;
        end else if (crc_acc != check_byte) begin
            r.status = tsc_pkg::ST_CHECKSUM;
        end else begin
            raw       = {temp_hi, temp_lo};
            scaled    = int'(raw) * ScaleE4;
            r.temp_e4 = scaled[tsc_pkg::TempW-1:0];
            r.status  = (scaled == ResetTempE4) ? tsc_pkg::ST_RESETVAL : tsc_pkg::ST_SUCCESS;
        end
        return r;
    endfunction

    task automatic restart_frame();
        byte_idx = '0;
        crc_acc  = '0;
        all_ff   = 1'b1;
        temp_lo  = '0;
        temp_hi  = '0;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        tsc_pkg::t_result want;
        tsc_pkg::t_result bus_err;
        if (!i_rst_n) begin
            restart_frame();
            pending_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d temp %0d",
                                              i_status, i_temperature_e4));
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_temperature_e4 !== want.temp_e4) begin
                        report_mismatch($sformatf("temperature_e4 %0d, expected %0d",
                                                  i_temperature_e4, want.temp_e4));
                    end
                end
            end
            if (i_push && !i_full) begin
                if (i_no_presence) begin
                    bus_err.status  = tsc_pkg::ST_BUS;
                    bus_err.temp_e4 = '0;
                    pending_results.push_back(bus_err);
                    restart_frame();
                end else if (byte_idx < LastByte) begin
                    crc_acc = crc8_step(crc_acc, i_data_byte);
                    if (i_data_byte != 8'hFF) begin
                        all_ff = 1'b0;
                    end
                    if (byte_idx == 4'd0) begin
                        temp_lo = i_data_byte;
                    end else if (byte_idx == 4'd1) begin
                        temp_hi = i_data_byte;
                    end
                    byte_idx = byte_idx + 4'd1;
                end else begin
                    pending_results.push_back(decode_frame(i_data_byte));
                    restart_frame();
                end
            end
        end
    end

endmodule

// ----- tb/tb_temp_sensor_scratchpad_check.sv -----
`timescale 1ns / 1ps

module tb_temp_sensor_scratchpad_check;

    localparam int ClkHalf     = 2;
    localparam int ResetCycles = 8;
    localparam int NumItems    = 750;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 200000;
    localparam logic [7:0] CrcPoly = 8'h8C;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               push          = 1'b0;
    logic               full;
    logic [7:0]         i_data_byte   = '0;
    logic               i_no_presence = 1'b0;
    logic               empty;
    logic               pop           = 1'b0;
    logic [2:0]         o_status;
    logic signed [25:0] o_temperature_e4;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;

    logic [7:0] pad [9];

    always #(ClkHalf) i_clk = ~i_clk;

    temp_sensor_scratchpad_check dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_no_presence    (i_no_presence),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_temperature_e4 (o_temperature_e4)
    );

    temp_sensor_scratchpad_check_monitor u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_no_presence    (i_no_presence),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_status         (o_status),
        .i_temperature_e4 (o_temperature_e4),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // check byte over pad[0..7], used to build well-formed frames
    function automatic logic [7:0] pad_crc();
        logic [7:0] crc;
        logic [7:0] b;
        logic       fb;
        crc = '0;
        for (int i = 0; i < 8; i++) begin
            b = pad[i];
            for (int k = 0; k < 8; k++) begin
                fb  = crc[0] ^ b[0];
                crc = crc >> 1;
                if (fb) begin
                    crc = crc ^ CrcPoly;
                end
                b = b >> 1;
            end
        end
        return crc;
    endfunction

    function automatic logic [15:0] pick_raw();
        logic [15:0] corners [7];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0550, 16'hFC90, 16'h0001};
        if ($urandom_range(0, 4) == 0) begin
            return corners[$urandom_range(0, 6)];
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic fill_frame(input logic [15:0] raw);
        pad[0] = raw[7:0];
        pad[1] = raw[15:8];
        for (int i = 2; i < 8; i++) begin
            pad[i] = 8'($urandom_range(0, 255));
        end
        pad[8] = pad_crc();
    endtask

    task automatic send_item(input logic [7:0] b, input logic np);
        case (items_sent * 4 / NumItems)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 84;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 84;
            end
            default: begin
                idle_pct  = 22;
                stall_pct = 22;
            end
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_data_byte   <= b;
        i_no_presence <= np;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_pad(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(pad[i], 1'b0);
        end
    endtask

    initial begin
        int kind;
        int j;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // power-on reset reading, then a silent bus with a matching check byte
        fill_frame(16'h0550);
        send_pad(9);
        for (int i = 0; i < 8; i++) begin
            pad[i] = 8'hFF;
        end
        pad[8] = pad_crc();
        send_pad(9);
        // missing presence on an idle frame and in mid-frame
        send_item(8'hA5, 1'b1);
        fill_frame(16'h8000);
        send_pad(3);
        send_item(8'hFF, 1'b1);

        while (items_sent < NumItems) begin
            kind = $urandom_range(0, 99);
            if (kind < 68) begin
                fill_frame(pick_raw());
                if ($urandom_range(0, 9) == 0) begin
                    // all 0xFF but one byte: must not read as silence
                    for (int i = 0; i < 8; i++) begin
                        pad[i] = 8'hFF;
                    end
                    j      = $urandom_range(0, 7);
                    pad[j] = 8'($urandom_range(0, 254));
                    pad[8] = pad_crc();
                end
                send_pad(9);
            end else if (kind < 80) begin
                fill_frame(pick_raw());
                pad[8] = pad[8] ^ 8'($urandom_range(1, 255));
                send_pad(9);
            end else if (kind < 87) begin
                for (int i = 0; i < 8; i++) begin
                    pad[i] = 8'hFF;
                end
                pad[8] = $urandom_range(0, 1) ? pad_crc() : 8'($urandom_range(0, 255));
                send_pad(9);
            end else if (kind < 97) begin
                fill_frame(pick_raw());
                send_pad($urandom_range(0, 8));
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // truncated frame, leaves the framing misaligned until the next abort
                fill_frame(pick_raw());
                send_pad($urandom_range(1, 8));
            end
        end
        push <= 1'b0;

        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
